// ===== hdl/tcle_pkg.sv =====
`timescale 1ns / 1ps

package tcle_pkg;

	// fixed field widths
	localparam int MODE_W = 4;
	localparam int CHAR_W = 8;
	localparam int INDEX_W = 11;
	localparam int COL_W = 7;
	localparam int ROW_W = 5;
	localparam int LEN_W = 11;
	localparam int CELL_W = 16;
	localparam int TAB_W = 5;
	localparam int CFG_W = 8;
	localparam int CFG_IDX_W = 2;

	// default geometry
	localparam int COLS_DEF = 80;
	localparam int ROWS_DEF = 25;
	localparam int HEADER_ROWS_DEF = 6;
	localparam int START_ROW_DEF = 8;
	localparam int PROMPT_WIDTH_DEF = 1;

	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	// character codes and colors
	localparam logic [CHAR_W-1:0] BLANK_CODE = 8'h20;
	localparam logic [CHAR_W-1:0] TAB_CODE = 8'h09;
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] HEADER_ATTR = 8'h82;
	localparam logic [7:0] PLAIN_ATTR = 8'h07;

	// register reset values
	localparam logic [TAB_W-1:0] TAB_WIDTH_RST = 5'd4;
	localparam logic [CHAR_W-1:0] ERASE_CODE_RST = 8'd8;
	localparam logic [CHAR_W-1:0] PROMPT_GLYPH_RST = 8'd62;
	localparam logic [7:0] PROMPT_ATTR_RST = 8'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERASE_CODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROMPT_GLYPH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PROMPT_ATTR = 2'd3;

	// command modes
	localparam logic [MODE_W-1:0] MODE_PUT = 4'd0;
	localparam logic [MODE_W-1:0] MODE_LEFT = 4'd1;
	localparam logic [MODE_W-1:0] MODE_RIGHT = 4'd2;
	localparam logic [MODE_W-1:0] MODE_HOME = 4'd3;
	localparam logic [MODE_W-1:0] MODE_END = 4'd4;
	localparam logic [MODE_W-1:0] MODE_DELETE = 4'd5;
	localparam logic [MODE_W-1:0] MODE_PROMPT = 4'd6;
	localparam logic [MODE_W-1:0] MODE_FG_NEXT = 4'd7;
	localparam logic [MODE_W-1:0] MODE_BG_NEXT = 4'd8;
	localparam logic [MODE_W-1:0] MODE_READ = 4'd9;

endpackage

// ===== hdl/tcle_addr_unit.sv =====
`timescale 1ns / 1ps

module tcle_addr_unit #(
	parameter int COLS = 80,
	parameter int SUM_W = 12
) (
	input logic [tcle_pkg::ROW_W-1:0] row,
	input logic [tcle_pkg::LEN_W-1:0] offset,
	output logic [SUM_W-1:0] sum
);
	import tcle_pkg::*;

	// row times width plus offset, the one multiplier in the block
	assign sum = SUM_W'(row) * SUM_W'(COLS) + SUM_W'(offset);

endmodule

// ===== hdl/tcle_cell_store.sv =====
`timescale 1ns / 1ps

module tcle_cell_store #(
	parameter int DEPTH = 2000,
	parameter int AW = 11
) (
	input logic clk,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input logic [tcle_pkg::CELL_W-1:0] wr_data,
	input logic rd_en,
	input logic [AW-1:0] rd_addr,
	output logic [tcle_pkg::CELL_W-1:0] rd_data
);
	import tcle_pkg::*;

	logic [CELL_W-1:0] mem_q [DEPTH];
	logic [CELL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/text_console_line_editor_core.sv =====
`timescale 1ns / 1ps

// channel   handshake                   payload
// item      item_valid / item_ready     mode, char_code, cell_index
// result    result_valid / result_ready cursor_x, cursor_y, edit_length, moved_flag, cell_word
// config    cfg_we (no wait)            cfg_index, cfg_data
//
// after reset a clearing pass writes every cell with item_ready low
// one item at a time: a plain put walks the PUT, ADV and NEXT states, a tab walks them once per space
// a scroll copies the rows below the header up by one row, a read and a write per cell, then blanks the bottom row
// delete and backspace shifts read and then write each moved cell, end subtracts COLS once per row of length
// a finished result waits in the output register until it is taken
// item_ready is low during the clear and from accept until the result enters it

module text_console_line_editor_core #(
	parameter int COLS = tcle_pkg::COLS_DEF,
	parameter int ROWS = tcle_pkg::ROWS_DEF,
	parameter int HEADER_ROWS = tcle_pkg::HEADER_ROWS_DEF,
	parameter int START_ROW = tcle_pkg::START_ROW_DEF,
	parameter int PROMPT_WIDTH = tcle_pkg::PROMPT_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input logic [tcle_pkg::MODE_W-1:0] mode,
	input logic [tcle_pkg::CHAR_W-1:0] char_code,
	input logic [tcle_pkg::INDEX_W-1:0] cell_index,
	output logic result_valid,
	input logic result_ready,
	output logic [tcle_pkg::COL_W-1:0] cursor_x,
	output logic [tcle_pkg::ROW_W-1:0] cursor_y,
	output logic [tcle_pkg::LEN_W-1:0] edit_length,
	output logic moved_flag,
	output logic [tcle_pkg::CELL_W-1:0] cell_word,
	input logic cfg_we,
	input logic [tcle_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tcle_pkg::CFG_W-1:0] cfg_data
);
	import tcle_pkg::*;

	localparam int CELLS = COLS * ROWS;
	localparam int AW = $clog2(CELLS);
	localparam int SUM_W = $clog2(CELLS + (1 << LEN_W));
	localparam int START_EFF = (START_ROW < ROWS - 1) ? START_ROW : ROWS - 1;
	localparam int FIRST_ROW = (HEADER_ROWS < ROWS - 1) ? HEADER_ROWS : ROWS - 1;
	localparam logic [SUM_W-1:0] SCROLL_BASE = SUM_W'(FIRST_ROW * COLS);
	localparam logic [SUM_W-1:0] BOTTOM_BASE = SUM_W'(COLS * (ROWS - 1));
	localparam logic [SUM_W-1:0] LAST_CELL = SUM_W'(CELLS - 1);
	localparam logic [COL_W-1:0] ANCHOR_COL = COL_W'(PROMPT_WIDTH + 1);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

	typedef enum logic [13:0] {
		ST_CLR = 14'b00000000000001,
		ST_IDLE = 14'b00000000000010,
		ST_EXEC = 14'b00000000000100,
		ST_END = 14'b00000000001000,
		ST_HERE = 14'b00000000010000,
		ST_PUT = 14'b00000000100000,
		ST_ADV = 14'b00000001000000,
		ST_NEXT = 14'b00000010000000,
		ST_CP_RD = 14'b00000100000000,
		ST_CP_WR = 14'b00001000000000,
		ST_FILL = 14'b00010000000000,
		ST_DIV = 14'b00100000000000,
		ST_RDW = 14'b01000000000000,
		ST_FIN = 14'b10000000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [TAB_W-1:0] tab_width_q;
	logic [CHAR_W-1:0] erase_code_q, prompt_glyph_q;
	logic [7:0] prompt_attr_q;

	// latched command
	logic [MODE_W-1:0] mode_q;
	logic [CHAR_W-1:0] char_q;
	logic [INDEX_W-1:0] index_q;

	// editor state
	logic [COL_W-1:0] cur_col_q;
	logic [ROW_W-1:0] cur_row_q, anchor_row_q;
	logic [LEN_W-1:0] line_count_q;
	logic [7:0] text_attr_q;

	// sequencer working registers
	logic [TAB_W-1:0] rep_q;
	logic extra_q, from_adv_q, scroll_q, moved_q;
	logic [SUM_W-1:0] ptr_q, lim_q, end_q;
	logic [LEN_W-1:0] rem_q, quo_q;
	logic [CHAR_W-1:0] glyph_q;
	logic [7:0] pattr_q;
	logic [CELL_W-1:0] word_q;
	logic [ROW_W-1:0] clr_row_q;
	logic [COL_W-1:0] clr_col_q;

	// result register
	logic result_valid_q, moved_out_q;
	logic [COL_W-1:0] cursor_x_q;
	logic [ROW_W-1:0] cursor_y_q;
	logic [LEN_W-1:0] edit_length_q;
	logic [CELL_W-1:0] cell_word_q;

	// shared address unit
	logic [ROW_W-1:0] au_row;
	logic [LEN_W-1:0] au_off;
	logic [SUM_W-1:0] au_sum;

	// store ports
	logic wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [CELL_W-1:0] wr_data, rd_data;

	logic left_ok, left_wrap, erase_blank, item_acc;
	logic [7:0] clr_attr;
	logic [SUM_W-1:0] end_clamp;
	logic [LEN_W:0] div_row;

	assign item_ready = (state_q == ST_IDLE);
	assign item_acc = item_valid && item_ready;

	// cursor left rule
	assign left_ok = (cur_row_q == anchor_row_q && cur_col_q > ANCHOR_COL) ||
		(cur_row_q > anchor_row_q && cur_col_q != '0);
	assign left_wrap = (cur_row_q > anchor_row_q) && (cur_col_q == '0);

	assign erase_blank = (state_q == ST_HERE) && (mode_q == MODE_PUT) && (au_sum == end_q);
	assign end_clamp = (end_q > LAST_CELL) ? LAST_CELL : end_q;
	assign div_row = (LEN_W + 1)'(anchor_row_q) + (LEN_W + 1)'(quo_q);
	assign clr_attr = (32'(clr_row_q) <= 32'(HEADER_ROWS)) ? HEADER_ATTR : PLAIN_ATTR;

	// address unit operand select
	always_comb begin
		au_row = cur_row_q;
		au_off = LEN_W'(cur_col_q);
		case (state_q)
			ST_CLR: begin
				au_row = clr_row_q;
				au_off = LEN_W'(clr_col_q);
			end
			ST_EXEC: begin
				au_row = cur_row_q - anchor_row_q;
			end
			ST_END: begin
				au_row = anchor_row_q;
				au_off = line_count_q;
			end
			default: begin
			end
		endcase
	end

	tcle_addr_unit #(
		.COLS(COLS),
		.SUM_W(SUM_W)
	) u_addr (
		.row(au_row),
		.offset(au_off),
		.sum(au_sum)
	);

	// store port select
	always_comb begin
		wr_en = 1'b0;
		wr_addr = AW'(au_sum);
		wr_data = {text_attr_q, BLANK_CODE};
		case (state_q)
			ST_CLR: begin
				wr_en = 1'b1;
				if (32'(clr_row_q) == START_EFF && clr_col_q == '0) begin
					wr_data = {PROMPT_ATTR_RST, PROMPT_GLYPH_RST};
				end else begin
					wr_data = {clr_attr, BLANK_CODE};
				end
			end
			ST_PUT: begin
				wr_en = 1'b1;
				wr_data = {pattr_q, glyph_q};
			end
			ST_HERE: begin
				wr_en = erase_blank;
			end
			ST_CP_WR: begin
				wr_en = 1'b1;
				wr_addr = AW'(ptr_q);
				wr_data = rd_data;
			end
			ST_FILL: begin
				wr_en = 1'b1;
				wr_addr = AW'(ptr_q);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		rd_en = 1'b0;
		rd_addr = AW'(index_q);
		if (state_q == ST_CP_RD) begin
			rd_en = (ptr_q < lim_q);
			rd_addr = AW'(scroll_q ? ptr_q + SUM_W'(COLS) : ptr_q + SUM_W'(1));
		end else if (state_q == ST_EXEC) begin
			rd_en = (mode_q == MODE_READ) && (32'(index_q) < CELLS);
		end
	end

	tcle_cell_store #(
		.DEPTH(CELLS),
		.AW(AW)
	) u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_width_q <= TAB_WIDTH_RST;
			erase_code_q <= ERASE_CODE_RST;
			prompt_glyph_q <= PROMPT_GLYPH_RST;
			prompt_attr_q <= PROMPT_ATTR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TAB_WIDTH: tab_width_q <= cfg_data[TAB_W-1:0];
				REG_ERASE_CODE: erase_code_q <= cfg_data;
				REG_PROMPT_GLYPH: prompt_glyph_q <= cfg_data;
				REG_PROMPT_ATTR: prompt_attr_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && (!result_valid_q || result_ready)) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && (!result_valid_q || result_ready)) begin
			cursor_x_q <= cur_col_q;
			cursor_y_q <= cur_row_q;
			edit_length_q <= line_count_q;
			moved_out_q <= moved_q;
			cell_word_q <= word_q;
		end
	end

	assign result_valid = result_valid_q;
	assign cursor_x = cursor_x_q;
	assign cursor_y = cursor_y_q;
	assign edit_length = edit_length_q;
	assign moved_flag = moved_out_q;
	assign cell_word = cell_word_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			cur_col_q <= ANCHOR_COL;
			cur_row_q <= ROW_W'(START_EFF);
			anchor_row_q <= ROW_W'(START_EFF);
			line_count_q <= '0;
			text_attr_q <= PLAIN_ATTR;
			clr_row_q <= '0;
			clr_col_q <= '0;
			rep_q <= '0;
			extra_q <= 1'b0;
			from_adv_q <= 1'b0;
			scroll_q <= 1'b0;
			moved_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: begin
					if (clr_col_q == LAST_COL) begin
						clr_col_q <= '0;
						clr_row_q <= clr_row_q + 1'b1;
						if (clr_row_q == LAST_ROW) begin
							state_q <= ST_IDLE;
						end
					end else begin
						clr_col_q <= clr_col_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (item_acc) begin
						mode_q <= mode;
						char_q <= char_code;
						index_q <= cell_index;
						moved_q <= 1'b0;
						word_q <= '0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
					case (mode_q)
						MODE_PUT: begin
							if (char_q == TAB_CODE) begin
								rep_q <= tab_width_q;
								glyph_q <= BLANK_CODE;
								pattr_q <= text_attr_q;
								extra_q <= 1'b0;
								if (tab_width_q != '0) begin
									state_q <= ST_PUT;
								end
							end else if (char_q == NEWLINE_CODE) begin
								cur_col_q <= '0;
								if (cur_row_q >= LAST_ROW) begin
									from_adv_q <= 1'b0;
									scroll_q <= 1'b1;
									ptr_q <= SCROLL_BASE;
									lim_q <= BOTTOM_BASE;
									state_q <= ST_CP_RD;
								end else begin
									cur_row_q <= cur_row_q + 1'b1;
								end
							end else if (char_q == erase_code_q) begin
								if (left_ok) begin
									cur_col_q <= cur_col_q - 1'b1;
									moved_q <= 1'b1;
									state_q <= ST_END;
								end else if (left_wrap) begin
									cur_row_q <= cur_row_q - 1'b1;
									cur_col_q <= LAST_COL;
									moved_q <= 1'b1;
									state_q <= ST_END;
								end
							end else begin
								rep_q <= TAB_W'(1);
								glyph_q <= char_q;
								pattr_q <= text_attr_q;
								extra_q <= 1'b0;
								state_q <= ST_PUT;
							end
						end
						MODE_LEFT: begin
							if (left_ok) begin
								cur_col_q <= cur_col_q - 1'b1;
								moved_q <= 1'b1;
							end else if (left_wrap) begin
								cur_row_q <= cur_row_q - 1'b1;
								cur_col_q <= LAST_COL;
								moved_q <= 1'b1;
							end
						end
						MODE_RIGHT: begin
							// position in the line from the shared unit
							if (cur_row_q >= anchor_row_q &&
								au_sum < SUM_W'(line_count_q)) begin
								moved_q <= 1'b1;
								if (cur_col_q != LAST_COL) begin
									cur_col_q <= cur_col_q + 1'b1;
								end else begin
									cur_col_q <= '0;
									if (cur_row_q < LAST_ROW) begin
										cur_row_q <= cur_row_q + 1'b1;
									end
								end
							end
						end
						MODE_HOME: begin
							cur_row_q <= anchor_row_q;
							cur_col_q <= ANCHOR_COL;
						end
						MODE_END: begin
							rem_q <= line_count_q;
							quo_q <= '0;
							state_q <= ST_DIV;
						end
						MODE_DELETE: begin
							state_q <= ST_END;
						end
						MODE_PROMPT: begin
							line_count_q <= '0;
							anchor_row_q <= cur_row_q;
							glyph_q <= prompt_glyph_q;
							pattr_q <= prompt_attr_q;
							rep_q <= TAB_W'(1);
							extra_q <= 1'b1;
							state_q <= ST_PUT;
						end
						MODE_FG_NEXT: begin
							text_attr_q[3:0] <= text_attr_q[3:0] + 1'b1;
						end
						MODE_BG_NEXT: begin
							text_attr_q[7:4] <= text_attr_q[7:4] + 1'b1;
						end
						MODE_READ: begin
							if (32'(index_q) < CELLS) begin
								state_q <= ST_RDW;
							end
						end
						default: begin
						end
					endcase
				end
				ST_END: begin
					end_q <= au_sum;
					state_q <= ST_HERE;
				end
				ST_HERE: begin
					state_q <= ST_FIN;
					if (mode_q == MODE_DELETE) begin
						if (au_sum < end_q) begin
							scroll_q <= 1'b0;
							ptr_q <= au_sum;
							lim_q <= end_clamp;
							state_q <= ST_CP_RD;
						end
					end else if (erase_blank) begin
						if (line_count_q != '0) begin
							line_count_q <= line_count_q - 1'b1;
						end
					end else begin
						scroll_q <= 1'b0;
						ptr_q <= au_sum;
						lim_q <= end_clamp;
						state_q <= ST_CP_RD;
					end
				end
				ST_PUT: begin
					rep_q <= rep_q - 1'b1;
					state_q <= ST_ADV;
				end
				ST_ADV: begin
					if (line_count_q != LEN_MAX) begin
						line_count_q <= line_count_q + 1'b1;
					end
					state_q <= ST_NEXT;
					if (cur_col_q == LAST_COL) begin
						cur_col_q <= '0;
						if (cur_row_q >= LAST_ROW) begin
							from_adv_q <= 1'b1;
							scroll_q <= 1'b1;
							ptr_q <= SCROLL_BASE;
							lim_q <= BOTTOM_BASE;
							state_q <= ST_CP_RD;
						end else begin
							cur_row_q <= cur_row_q + 1'b1;
						end
					end else begin
						cur_col_q <= cur_col_q + 1'b1;
					end
				end
				ST_NEXT: begin
					if (extra_q) begin
						extra_q <= 1'b0;
						state_q <= ST_ADV;
					end else if (rep_q != '0) begin
						state_q <= ST_PUT;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_CP_RD: begin
					if (ptr_q < lim_q) begin
						state_q <= ST_CP_WR;
					end else if (scroll_q) begin
						ptr_q <= BOTTOM_BASE;
						state_q <= ST_FILL;
					end else begin
						if (line_count_q != '0) begin
							line_count_q <= line_count_q - 1'b1;
						end
						state_q <= ST_FIN;
					end
				end
				ST_CP_WR: begin
					ptr_q <= ptr_q + 1'b1;
					state_q <= ST_CP_RD;
				end
				ST_FILL: begin
					if (ptr_q == LAST_CELL) begin
						if (anchor_row_q != '0) begin
							anchor_row_q <= anchor_row_q - 1'b1;
						end
						state_q <= from_adv_q ? ST_NEXT : ST_FIN;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_DIV: begin
					// repeated subtract of the row width
					if (rem_q >= LEN_W'(COLS)) begin
						rem_q <= rem_q - LEN_W'(COLS);
						quo_q <= quo_q + 1'b1;
					end else begin
						cur_col_q <= COL_W'(rem_q);
						cur_row_q <= (div_row > (LEN_W + 1)'(LAST_ROW)) ?
							LAST_ROW : ROW_W'(div_row);
						state_q <= ST_FIN;
					end
				end
				ST_RDW: begin
					word_q <= rd_data;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!result_valid_q || result_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// cursor stays on the screen in every result
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (32'(cursor_x) < COLS) && (32'(cursor_y) < ROWS))
		else $error("cursor outside the screen");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while busy");

	// no item during the clearing pass
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |-> !item_ready)
		else $error("ready during clear");

endmodule
